// ===== hdl/chs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_pkg
// Types, sizes and codes shared by the chained hash set and its units.
// ----------------------------------------------------------------------------
package chs_pkg;

	// Table geometry
	localparam int unsigned BUCKET_COUNT     = 101;
	localparam int unsigned SLOTS_PER_BUCKET = 8;
	localparam int unsigned SLOT_TOTAL       = BUCKET_COUNT * SLOTS_PER_BUCKET;

	// Field and index widths
	localparam int unsigned KEY_W    = 31;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ADDR_W   = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
	localparam int unsigned BUCKET_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int unsigned SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int unsigned CNT_W    = $clog2(SLOTS_PER_BUCKET + 1);

	// Reciprocal for key / BUCKET_COUNT; the estimate is the quotient or one less
	localparam int unsigned RECIP_SHIFT = 37;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam int unsigned PROD_W      = KEY_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / BUCKET_COUNT);

	// Request kinds; code three is unused and answers not found
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	// Result codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_MISSING = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_SCAN,
		ST_RESP
	} state_t;

	// Modulo unit handshake
	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
	} mod_req_t;

	typedef struct packed {
		logic                done;
		logic [BUCKET_W-1:0] bucket;
	} mod_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/chs_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_ifs
// Valid/ready channels of the chained hash set: request and response.
// ----------------------------------------------------------------------------
interface chs_req_if;
	logic                       valid;
	logic                       ready;
	logic [chs_pkg::KIND_W-1:0] kind;
	logic [chs_pkg::KEY_W-1:0]  key;

	modport source (output valid, output kind, output key, input ready);
	modport sink   (input valid, input kind, input key, output ready);
endinterface

interface chs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [chs_pkg::STATUS_W-1:0] status;

	modport source (output valid, output status, input ready);
	modport sink   (input valid, input status, output ready);
endinterface
`default_nettype wire

// ===== hdl/chs_mod_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_mod_unit
// Three-stage bucket hash: key mod BUCKET_COUNT by reciprocal multiply,
// back-multiply and one corrective subtract.
// ----------------------------------------------------------------------------
module chs_mod_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire chs_pkg::mod_req_t req,
	output chs_pkg::mod_rsp_t      rsp
);

	logic                         v_s1, v_s2, v_s3;
	logic [chs_pkg::PROD_W-1:0]   prod_s1;
	logic [chs_pkg::KEY_W-1:0]    key_s1, key_s2;
	logic [chs_pkg::KEY_W-1:0]    qm_s2;
	logic [chs_pkg::KEY_W-1:0]    rem_raw;
	logic [chs_pkg::KEY_W-1:0]    rem_fix;
	logic [chs_pkg::BUCKET_W-1:0] bucket_s3;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: key times reciprocal
	always_ff @(posedge clk) begin
		prod_s1 <= chs_pkg::PROD_W'(req.key) * chs_pkg::PROD_W'(chs_pkg::RECIP);
		key_s1  <= req.key;
	end

	// Stage 2: quotient estimate times bucket count
	always_ff @(posedge clk) begin
		qm_s2  <= chs_pkg::KEY_W'(
			prod_s1[chs_pkg::RECIP_SHIFT +: chs_pkg::KEY_W] *
			chs_pkg::KEY_W'(chs_pkg::BUCKET_COUNT));
		key_s2 <= key_s1;
	end

	// Stage 3: remainder below twice the count, one correction
	assign rem_raw = key_s2 - qm_s2;
	assign rem_fix = (rem_raw >= chs_pkg::KEY_W'(chs_pkg::BUCKET_COUNT)) ?
		rem_raw - chs_pkg::KEY_W'(chs_pkg::BUCKET_COUNT) : rem_raw;

	always_ff @(posedge clk) begin
		bucket_s3 <= chs_pkg::BUCKET_W'(rem_fix);
	end

	assign rsp.done   = v_s3;
	assign rsp.bucket = bucket_s3;

	// Checks
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> rem_raw < chs_pkg::KEY_W'(2 * chs_pkg::BUCKET_COUNT))
		else $error("hash remainder estimate out of range");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> 32'(bucket_s3) < chs_pkg::BUCKET_COUNT)
		else $error("bucket index out of range");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> ##3 rsp.done)
		else $error("hash result missing three cycles after start");

endmodule
`default_nettype wire

// ===== hdl/chained_hash_set.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_set
// Hashed multiset of 31-bit keys: insert, lookup and delete one key per
// transaction, with a fixed number of slots per bucket in one slot memory.
//
// Each request is hashed to a bucket, then the slot scan reads the bucket's slots,
// one memory read a cycle, until a hit or the last slot; the response is then registered.
// Throughput: one transaction at a time; the next request is taken once the
// response is in the output register, which holds it while the sink stalls.
// Reset: a clearing pass writes all SLOT_TOTAL (808) slots empty,
// during which no request is accepted.
// ----------------------------------------------------------------------------
module chained_hash_set (
	input  wire logic  clk,
	input  wire logic  arst_n,
	chs_req_if.sink    req,
	chs_rsp_if.source  rsp
);

	chs_pkg::state_t              state_q, state_d;
	chs_pkg::kind_t               kind_q;
	logic [chs_pkg::KIND_W-1:0]   kind_raw_q;
	logic [chs_pkg::KEY_W-1:0]    key_q;
	logic [chs_pkg::ADDR_W-1:0]   base_q;
	logic [chs_pkg::ADDR_W-1:0]   clr_idx_q;
	logic [chs_pkg::CNT_W-1:0]    scan_idx_q;
	logic [chs_pkg::SLOT_W-1:0]   hit_slot_q;
	logic                         found_q;
	logic                         chk_vld_s1;
	logic [chs_pkg::SLOT_W-1:0]   chk_slot_s1;
	logic [chs_pkg::KEY_W:0]      rd_data_s1;
	logic                         rsp_vld_q;
	chs_pkg::status_t             rsp_status_q;

	chs_pkg::mod_req_t            mod_req;
	chs_pkg::mod_rsp_t            mod_rsp;

	logic                         accept;
	logic                         rd_en;
	logic [chs_pkg::ADDR_W-1:0]   rd_addr;
	logic                         wr_en;
	logic [chs_pkg::ADDR_W-1:0]   wr_addr;
	logic [chs_pkg::KEY_W:0]      wr_data;
	logic                         entry_valid;
	logic [chs_pkg::KEY_W-1:0]    entry_key;
	logic                         hit_now;
	logic                         last_chk;
	logic                         rsp_load;
	logic                         is_ins, is_del, is_lkp;
	chs_pkg::status_t             status_d;

	// Slot memory: {valid, key}
	logic [chs_pkg::KEY_W:0] slot_mem [chs_pkg::SLOT_TOTAL];

	// Request channel
	assign req.ready = (state_q == chs_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Bucket hash unit
	assign mod_req.start = accept;
	assign mod_req.key   = req.key;

	chs_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Kind decode
	assign is_ins = (kind_raw_q == chs_pkg::KIND_INSERT);
	assign is_lkp = (kind_raw_q == chs_pkg::KIND_LOOKUP);
	assign is_del = (kind_raw_q == chs_pkg::KIND_DELETE);

	// Returned slot check
	assign entry_valid = rd_data_s1[chs_pkg::KEY_W];
	assign entry_key   = rd_data_s1[chs_pkg::KEY_W-1:0];
	assign hit_now     = (state_q == chs_pkg::ST_SCAN) && chk_vld_s1 &&
		(is_ins ? !entry_valid : ((is_lkp || is_del) && entry_valid && entry_key == key_q));
	assign last_chk    = (state_q == chs_pkg::ST_SCAN) && chk_vld_s1 &&
		(chk_slot_s1 == chs_pkg::SLOT_W'(chs_pkg::SLOTS_PER_BUCKET - 1));

	// Scan reads, one slot a cycle, stopped by a hit
	assign rd_en   = (state_q == chs_pkg::ST_SCAN) &&
		(scan_idx_q < chs_pkg::CNT_W'(chs_pkg::SLOTS_PER_BUCKET)) && !hit_now;
	assign rd_addr = base_q + chs_pkg::ADDR_W'(scan_idx_q[chs_pkg::SLOT_W-1:0]);

	// Response code
	always_comb begin
		status_d = chs_pkg::STATUS_MISSING;
		case (kind_q)
			chs_pkg::KIND_INSERT: status_d = found_q ? chs_pkg::STATUS_OK : chs_pkg::STATUS_FULL;
			chs_pkg::KIND_LOOKUP: status_d = found_q ? chs_pkg::STATUS_OK : chs_pkg::STATUS_MISSING;
			chs_pkg::KIND_DELETE: status_d = found_q ? chs_pkg::STATUS_OK : chs_pkg::STATUS_MISSING;
			default:              status_d = chs_pkg::STATUS_MISSING;
		endcase
	end

	assign rsp_load = (state_q == chs_pkg::ST_RESP) && (!rsp_vld_q || rsp.ready);

	// Write port: clearing pass, or the one update as the response leaves
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = base_q + chs_pkg::ADDR_W'(hit_slot_q);
		wr_data = {1'b0, key_q};
		if (state_q == chs_pkg::ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else if (rsp_load && found_q && (is_ins || is_del)) begin
			wr_en   = 1'b1;
			wr_data = {is_ins, key_q};
		end
	end

	// Memory; the sequencer never reads and writes in the same cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= slot_mem[rd_addr];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			chs_pkg::ST_CLEAR: begin
				if (clr_idx_q == chs_pkg::ADDR_W'(chs_pkg::SLOT_TOTAL - 1)) begin
					state_d = chs_pkg::ST_IDLE;
				end
			end
			chs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = chs_pkg::ST_HASH;
				end
			end
			chs_pkg::ST_HASH: begin
				if (mod_rsp.done) begin
					state_d = chs_pkg::ST_SCAN;
				end
			end
			chs_pkg::ST_SCAN: begin
				if (hit_now || last_chk) begin
					state_d = chs_pkg::ST_RESP;
				end
			end
			chs_pkg::ST_RESP: begin
				if (rsp_load) begin
					state_d = chs_pkg::ST_IDLE;
				end
			end
			default: state_d = chs_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= chs_pkg::ST_CLEAR;
			clr_idx_q  <= '0;
			scan_idx_q <= '0;
			chk_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= rd_en;
			if (state_q == chs_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (state_q == chs_pkg::ST_HASH) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (hit_now) begin
				found_q <= 1'b1;
			end else if (last_chk) begin
				found_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= chs_pkg::kind_t'(req.kind);
			kind_raw_q <= req.kind;
			key_q      <= req.key;
		end
		if (state_q == chs_pkg::ST_HASH && mod_rsp.done) begin
			base_q <= chs_pkg::ADDR_W'(mod_rsp.bucket * chs_pkg::SLOTS_PER_BUCKET);
		end
		chk_slot_s1 <= scan_idx_q[chs_pkg::SLOT_W-1:0];
		if (hit_now) begin
			hit_slot_q <= chk_slot_s1;
		end
		if (rsp_load) begin
			rsp_status_q <= status_d;
		end
	end

	// Response channel
	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = chs_pkg::STATUS_W'(rsp_status_q);

	// Checks
	a_chk_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> $past(rd_en))
		else $error("slot check without a preceding read");

	a_update_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != chs_pkg::ST_CLEAR) |-> (found_q && (is_ins || is_del)))
		else $error("slot written without a matching hit");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q) == chs_pkg::ST_RESP)
		else $error("response raised outside the response state");

	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == chs_pkg::ST_HASH)
		else $error("accepted request did not start the hash");

endmodule
`default_nettype wire
